// ===== design/upd_pkg.sv =====
// shared types, character constants and hex digit decode for the url percent decoder
package upd_pkg;

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam int unsigned NIBBLE_SHIFT = 4;

    localparam int unsigned MAX_OUT      = 3;
    localparam int unsigned OUT_CNT_W    = $clog2(MAX_OUT + 1);
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_PLUS_IS_SPACE = 3'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0]        cnt;
        logic [MAX_OUT-1:0][7:0]     bytes;
        logic                        last;
    } cmd_t;

    // 0..15 for a hex digit, 16 for anything else
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h41 + 8'd10);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

// ===== design/url_percent_decoder_core.sv =====
// top level of the url percent decoder: register port, front end, queue and back end
//
// Input channel s_valid/s_ready/s_item carries one encoded byte per item with
// in_last on the final byte of a message. Output channel m_valid/m_ready/m_item
// carries decoded bytes, out_last on the final decoded byte of the message.
// The APB port holds plus_is_space at address 0; write it only while idle.
// An input item may produce zero, one, two or three output items: a held
// percent sign or first digit is released when the escape is decided or the
// message ends.
// An accepted byte is written into the command queue, then into the output
// register that drives m_item. Throughput: one input item per cycle while each
// yields at most one byte and the queue has room; the back end emits one byte
// per cycle while m_ready allows, so items yielding two or three bytes hold it
// until all are out, and a four-entry command queue absorbs bursts. When the
// receiver stalls, the output register holds and the queue fills; s_ready drops
// only when the queue is full. Reset (aresetn low, synchronous) clears the
// escape state, the queue, the output valid and plus_is_space.
module url_percent_decoder_core
    import upd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    logic              plus_reg;
    logic              cfg_wr;
    logic              push;
    cmd_t              cmd;
    logic              pop;
    cmd_t              head;
    logic              head_valid;
    logic              q_full;
    logic [QCNT_W-1:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_PLUS_IS_SPACE) ? {31'b0, plus_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_reg <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_PLUS_IS_SPACE[2]) begin
            plus_reg <= pwdata[0];
        end
    end

    assign s_ready = !q_full;

    upd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .plus_is_space (plus_reg),
        .push          (push),
        .cmd           (cmd)
    );

    upd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full),
        .count      (q_count)
    );

    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    a_no_empty_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> cmd.cnt != '0)
        else $error("empty command pushed");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full && !pop |=> q_count == QCNT_W'(QUEUE_DEPTH) || $past(!push))
        else $error("push into full queue");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid && m_valid && m_ready |=> !m_valid)
        else $error("output valid without queued command");

    a_cmd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> head.cnt != '0 && head.cnt <= OUT_CNT_W'(MAX_OUT))
        else $error("bad command byte count at queue head");

endmodule

// ===== design/upd_front.sv =====
// front end: accepts items, tracks escape state and issues emit commands
module upd_front
    import upd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  in_item_t s_item,
    input  logic     plus_is_space,
    output logic     push,
    output cmd_t     cmd
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic       accept;
    logic [7:0] b;
    logic       lst;
    logic [4:0] hv;
    logic [4:0] held_hv;
    logic       is_hex;
    logic       p_emit;
    logic [7:0] p_byte;
    logic [1:0] p_phase;

    assign accept  = s_valid & s_ready;
    assign b       = s_item.in_byte;
    assign lst     = s_item.in_last;
    assign hv      = hex_value(b);
    assign held_hv = hex_value(held_reg);
    assign is_hex  = ~hv[4];

    // plain handling with no escape pending
    assign p_emit  = !(b == CH_PERCENT && !lst);
    assign p_byte  = (b == CH_PLUS && plus_is_space) ? CH_SPACE : b;
    assign p_phase = p_emit ? PH_IDLE : PH_PCT;

    always_comb begin
        cmd        = '0;
        cmd.last   = lst;
        phase_next = phase_reg;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_PCT: begin
                if (is_hex) begin
                    if (lst) begin
                        cmd.cnt      = OUT_CNT_W'(2);
                        cmd.bytes[0] = CH_PERCENT;
                        cmd.bytes[1] = b;
                        phase_next   = PH_IDLE;
                    end else begin
                        held_next  = b;
                        phase_next = PH_DIGIT;
                    end
                end else begin
                    cmd.cnt      = p_emit ? OUT_CNT_W'(2) : OUT_CNT_W'(1);
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = p_byte;
                    phase_next   = p_phase;
                end
            end
            PH_DIGIT: begin
                if (is_hex) begin
                    cmd.cnt      = OUT_CNT_W'(1);
                    cmd.bytes[0] = ({4'b0, held_hv[3:0]} << NIBBLE_SHIFT) | {4'b0, hv[3:0]};
                    phase_next   = PH_IDLE;
                end else begin
                    cmd.cnt      = p_emit ? OUT_CNT_W'(3) : OUT_CNT_W'(2);
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = held_reg;
                    cmd.bytes[2] = p_byte;
                    phase_next   = p_phase;
                end
            end
            default: begin
                cmd.cnt      = p_emit ? OUT_CNT_W'(1) : OUT_CNT_W'(0);
                cmd.bytes[0] = p_byte;
                phase_next   = p_phase;
            end
        endcase
    end

    assign push = accept && (cmd.cnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== design/upd_queue.sv =====
// short command queue between front and back end
module upd_queue
    import upd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cmd_t              push_cmd,
    input  logic              pop,
    output cmd_t              head,
    output logic              head_valid,
    output logic              full,
    output logic [QCNT_W-1:0] count
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign count      = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/upd_back.sv =====
// back end: walks the head command and emits one byte per cycle into the output register while m_ready allows
module upd_back
    import upd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      head,
    input  logic      head_valid,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [OUT_CNT_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;
    logic                 emit;
    logic                 last_byte;

    assign emit      = head_valid && (!m_valid_reg || m_ready);
    assign last_byte = (idx_reg == head.cnt - OUT_CNT_W'(1));
    assign pop       = emit && last_byte;

    always_comb begin
        idx_next     = idx_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next         = 1'b1;
            m_item_next.out_byte = head.bytes[idx_reg[1:0]];
            m_item_next.out_last = head.last && last_byte;
            idx_next             = last_byte ? '0 : idx_reg + OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
